/* hdl/hbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP body dechunker package
// Shared types and codes for the dechunker top level and its checker.
// ----------------------------------------------------------------------------
package hbd_pkg;

  // Width of the configuration write data: the widest register.
  localparam int unsigned CfgDataW = 48;
  // Width of the content length register.
  localparam int unsigned ContentLenW = 48;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_BODY_MODE      = 1'b0,
    REG_CONTENT_LENGTH = 1'b1
  } reg_idx_e;

  // Body framing modes (code 3 behaves as until-close).
  typedef enum logic [1:0] {
    MODE_CHUNKED   = 2'd0,
    MODE_LENGTH    = 2'd1,
    MODE_CLOSE     = 2'd2,
    MODE_CLOSE_ALT = 2'd3
  } mode_e;

  // Error codes reported with each result.
  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_EMPTY_SIZE  = 3'd1,
    ERR_BAD_SIZE    = 3'd2,
    ERR_AFTER_END   = 3'd3,
    ERR_EARLY_CLOSE = 3'd4
  } err_e;

  // Input item kinds.
  typedef enum logic [0:0] {
    KIND_BYTE  = 1'b0,
    KIND_CLOSE = 1'b1
  } kind_e;

  // Chunked parser phases.
  typedef enum logic [1:0] {
    PH_SIZE = 2'd0,
    PH_CR   = 2'd1,
    PH_DATA = 2'd2,
    PH_SKIP = 2'd3
  } phase_e;

  // Delimiter characters.
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

endpackage

/* hdl/http_body_dechunker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP body dechunker
// Recovers the payload bytes of an HTTP message body in chunked, fixed
// length or until-close mode.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the input channel (in_valid_i / in_ready_o) as a kind
// (body byte or connection close) and a byte. Every request produces exactly
// one result on the output channel (out_valid_o / out_ready_i): a payload
// byte with its valid flag, an end-of-body flag and an error code.
// The block has an input register and a result register with the parsing
// logic between them. An accepted request waits in the input register and
// moves on once the result register is free or being taken. One request
// is taken in every cycle while results are drained. The rate is set by the
// single state update per byte in the parsing stage. When the receiver
// stalls, the result register holds and one further request is still taken
// into the input register; after that in_ready_o drops until the result is
// taken.
// Configuration (cfg_we_i, cfg_index_i, cfg_wdata_i) is to be written by the
// user only while the block is idle, which the block itself does not enforce;
// parse state is kept across writes. Reset clears both registers, the parse
// state and the configuration (chunked mode, content length zero).
// ----------------------------------------------------------------------------
module http_body_dechunker_unit #(
  parameter int unsigned LENGTH_BITS     = 48,
  parameter int unsigned CHUNK_SIZE_BITS = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port
  input  logic                         cfg_we_i,
  input  hbd_pkg::reg_idx_e            cfg_index_i,
  input  logic [hbd_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic [7:0]                   in_byte_i,
  // Output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         payload_valid_o,
  output logic [7:0]                   payload_byte_o,
  output logic                         body_end_o,
  output hbd_pkg::err_e                error_code_o
);
  import hbd_pkg::*;

  localparam int unsigned CmpW = (LENGTH_BITS > ContentLenW) ? LENGTH_BITS : ContentLenW;
  localparam logic [LENGTH_BITS-1:0] LenMax = {LENGTH_BITS{1'b1}};

  // Hex digit decode; the valid flag is low for anything but 0-9, a-f, A-F.
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // Configuration registers.
  mode_e                  body_mode_q;
  logic [ContentLenW-1:0] content_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_mode_q      <= MODE_CHUNKED;
      content_length_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BODY_MODE:      body_mode_q <= mode_e'(cfg_wdata_i[1:0]);
        REG_CONTENT_LENGTH: content_length_q <= cfg_wdata_i[ContentLenW-1:0];
        default:            ;
      endcase
    end
  end

  // Input register stage.
  logic       in_valid_q;
  kind_e      kind_q;
  logic [7:0] byte_q;
  logic       advance;

  assign advance    = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_e'(kind_i);
      byte_q <= in_byte_i;
    end
  end

  // Parse state.
  phase_e                     phase_q, phase_d;
  logic [CHUNK_SIZE_BITS-1:0] chunk_left_q, chunk_left_d;
  logic                       digit_seen_q, digit_seen_d;
  logic                       last_chunk_q, last_chunk_d;
  logic [1:0]                 skip_left_q, skip_left_d;
  logic [LENGTH_BITS-1:0]     count_q, count_d;
  logic                       ended_q, ended_d;

  // Result fields computed in the parsing stage.
  logic  res_pvalid, res_end;
  err_e  res_err;

  logic [4:0]             hex;
  logic [LENGTH_BITS-1:0] count_inc;
  logic                   len_reached, len_reached_inc;
  logic [CHUNK_SIZE_BITS-1:0] chunk_dec;
  logic [1:0]             skip_dec;

  assign hex             = hex_decode(byte_q);
  assign count_inc       = (count_q == LenMax) ? count_q : count_q + LENGTH_BITS'(1);
  assign len_reached     = CmpW'(count_q) >= CmpW'(content_length_q);
  assign len_reached_inc = CmpW'(count_inc) >= CmpW'(content_length_q);
  assign chunk_dec       = (chunk_left_q != '0) ? chunk_left_q - CHUNK_SIZE_BITS'(1) :
                                                  chunk_left_q;
  assign skip_dec        = (skip_left_q != 2'd0) ? skip_left_q - 2'd1 : skip_left_q;

  // Next state and result for the request in the input register.
  always_comb begin
    phase_d      = phase_q;
    chunk_left_d = chunk_left_q;
    digit_seen_d = digit_seen_q;
    last_chunk_d = last_chunk_q;
    skip_left_d  = skip_left_q;
    count_d      = count_q;
    ended_d      = ended_q;
    res_pvalid   = 1'b0;
    res_end      = 1'b0;
    res_err      = ERR_NONE;

    if (kind_q == KIND_CLOSE) begin
      if (!ended_q) begin
        ended_d = 1'b1;
        if (body_mode_q == MODE_CHUNKED) begin
          res_err = ERR_EARLY_CLOSE;
        end else if (body_mode_q == MODE_LENGTH && !len_reached) begin
          res_err = ERR_EARLY_CLOSE;
        end else begin
          res_end = 1'b1;
        end
      end
    end else if (ended_q) begin
      res_err = ERR_AFTER_END;
    end else begin
      case (body_mode_q)
        MODE_CHUNKED: begin
          case (phase_q)
            PH_SIZE: begin
              if (byte_q == ChCr) begin
                phase_d = PH_CR;
              end else if (!hex[4] ||
                           chunk_left_q[CHUNK_SIZE_BITS-1:CHUNK_SIZE_BITS-4] != 4'd0) begin
                ended_d = 1'b1;
                res_err = ERR_BAD_SIZE;
              end else begin
                chunk_left_d = {chunk_left_q[CHUNK_SIZE_BITS-5:0], hex[3:0]};
                digit_seen_d = 1'b1;
              end
            end
            PH_CR: begin
              if (byte_q != ChLf) begin
                ended_d = 1'b1;
                res_err = ERR_BAD_SIZE;
              end else if (!digit_seen_q) begin
                ended_d = 1'b1;
                res_err = ERR_EMPTY_SIZE;
              end else begin
                digit_seen_d = 1'b0;
                if (chunk_left_q == '0) begin
                  last_chunk_d = 1'b1;
                  phase_d      = PH_SKIP;
                  skip_left_d  = 2'd2;
                end else begin
                  last_chunk_d = 1'b0;
                  phase_d      = PH_DATA;
                end
              end
            end
            PH_DATA: begin
              count_d      = count_inc;
              chunk_left_d = chunk_dec;
              res_pvalid   = 1'b1;
              if (chunk_dec == '0) begin
                phase_d     = PH_SKIP;
                skip_left_d = 2'd2;
              end
            end
            default: begin
              skip_left_d = skip_dec;
              if (skip_dec == 2'd0) begin
                phase_d      = PH_SIZE;
                chunk_left_d = '0;
                if (last_chunk_q) begin
                  ended_d = 1'b1;
                  res_end = 1'b1;
                end
              end
            end
          endcase
        end
        MODE_LENGTH: begin
          if (len_reached) begin
            ended_d = 1'b1;
            res_err = ERR_AFTER_END;
          end else begin
            count_d    = count_inc;
            res_pvalid = 1'b1;
            if (len_reached_inc) begin
              ended_d = 1'b1;
              res_end = 1'b1;
            end
          end
        end
        default: begin
          count_d    = count_inc;
          res_pvalid = 1'b1;
        end
      endcase
    end
  end

  // Parse state registers, updated as a request moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SIZE;
      chunk_left_q <= '0;
      digit_seen_q <= 1'b0;
      last_chunk_q <= 1'b0;
      skip_left_q  <= 2'd0;
      count_q      <= '0;
      ended_q      <= 1'b0;
    end else if (advance) begin
      phase_q      <= phase_d;
      chunk_left_q <= chunk_left_d;
      digit_seen_q <= digit_seen_d;
      last_chunk_q <= last_chunk_d;
      skip_left_q  <= skip_left_d;
      count_q      <= count_d;
      ended_q      <= ended_d;
    end
  end

  // Result register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      payload_valid_o <= res_pvalid;
      payload_byte_o  <= res_pvalid ? byte_q : 8'd0;
      body_end_o      <= res_end;
      error_code_o    <= res_err;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hdl/hbd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP body dechunker checker
// Port-level assertions on the dechunker results, bound to the top level.
// ----------------------------------------------------------------------------
module hbd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input logic          payload_valid_o,
  input logic [7:0]    payload_byte_o,
  input logic          body_end_o,
  input hbd_pkg::err_e error_code_o
);
  import hbd_pkg::*;

  // A stalled result holds its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(payload_byte_o) &&
      $stable(payload_valid_o) && $stable(body_end_o) && $stable(error_code_o))
    else $error("stalled result changed");

  // No result is shown straight out of reset.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid after reset");

  // A result without payload carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !payload_valid_o |-> payload_byte_o == 8'd0)
    else $error("payload byte set without payload");

  // An error never comes with payload or with the end of the body.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_NONE |-> !payload_valid_o && !body_end_o)
    else $error("error result carries payload or end");

endmodule

bind http_body_dechunker_unit hbd_checker u_hbd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .payload_valid_o (payload_valid_o),
  .payload_byte_o  (payload_byte_o),
  .body_end_o      (body_end_o),
  .error_code_o    (error_code_o)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP body dechunker testbench
// Drives byte and close requests through the dechunker in every body mode,
// predicts each result from its own copy of the parse state and compares the
// results field by field. Reset is applied once, so the run builds one long
// body: chunked data, until-close and fixed-length stretches, more chunks,
// then one randomly chosen way of ending the body and some traffic after it.
// ----------------------------------------------------------------------------
module tb_top;
  import hbd_pkg::*;

  localparam int unsigned LenW   = 48;
  localparam int unsigned ChunkW = 31;
  localparam logic [LenW-1:0] LenMax = '1;

  // One result as the block reports it.
  typedef struct packed {
    logic       pay_valid;
    logic [7:0] pay_byte;
    logic       body_end;
    err_e       err;
  } body_res_t;

  // One request waiting to be offered.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } body_req_t;

  // Ways of finishing the body at the end of the run.
  typedef enum int unsigned {
    FIN_LAST_CHUNK,
    FIN_EMPTY_LINE,
    FIN_BAD_DIGIT,
    FIN_BAD_LF,
    FIN_OVERSIZE,
    FIN_CHUNK_CLOSE,
    FIN_LEN_DONE,
    FIN_LEN_ZERO,
    FIN_LEN_SHORT,
    FIN_LEN_CLOSE,
    FIN_OPEN_CLOSE
  } finale_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  reg_idx_e             cfg_index_i = REG_BODY_MODE;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 kind_i      = 1'b0;
  logic [7:0]           in_byte_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 payload_valid_o;
  logic [7:0]           payload_byte_o;
  logic                 body_end_o;
  err_e                 error_code_o;

  // Predicted configuration and parse state.
  mode_e             mode_q     = MODE_CHUNKED;
  logic [LenW-1:0]   len_q      = '0;
  phase_e            chk_phase  = PH_SIZE;
  logic [ChunkW-1:0] chunk_left = '0;
  logic              digit_seen = 1'b0;
  logic              last_chunk = 1'b0;
  logic [1:0]        skip_left  = '0;
  logic [LenW-1:0]   byte_cnt   = '0;
  logic              body_done  = 1'b0;

  body_req_t pending_q[$];
  body_res_t expect_q[$];
  body_req_t drv_req;
  body_res_t mon_want;

  int fail_cnt       = 0;
  int accepted_cnt   = 0;
  int send_gap       = 0;
  int hold_cycles    = 0;
  bit long_hold_done = 1'b0;
  bit calm           = 1'b0;

  always #5 clk_i = ~clk_i;

  http_body_dechunker_unit #(
    .LENGTH_BITS    (LenW),
    .CHUNK_SIZE_BITS(ChunkW)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_valid_o(payload_valid_o),
    .payload_byte_o (payload_byte_o),
    .body_end_o     (body_end_o),
    .error_code_o   (error_code_o)
  );

  // Value of a hex digit character, or -1 for anything else.
  function automatic int hex_nibble(logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
    if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
    if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
    if (nib < 4'd10) return "0" + {4'h0, nib};
    return (upper ? "A" : "a") + {4'h0, nib} - 8'd10;
  endfunction

  // The payload byte counter saturates rather than wrapping.
  function automatic void bump_count();
    if (byte_cnt != LenMax) byte_cnt++;
  endfunction

  // Advances the predicted state by one request and returns its result.
  function automatic body_res_t predict_body(kind_e k, logic [7:0] b);
    body_res_t r;
    int nib;
    r = '0;
    if (k == KIND_CLOSE) begin
      if (body_done) return r;
      body_done = 1'b1;
      if (mode_q == MODE_CHUNKED || (mode_q == MODE_LENGTH && byte_cnt < len_q)) begin
        r.err = ERR_EARLY_CLOSE;
      end else begin
        r.body_end = 1'b1;
      end
      return r;
    end
    if (body_done) begin
      r.err = ERR_AFTER_END;
      return r;
    end
    case (mode_q)
      MODE_CHUNKED: begin
        case (chk_phase)
          PH_SIZE: begin
            if (b == ChCr) begin
              chk_phase = PH_CR;
            end else begin
              nib = hex_nibble(b);
              if (nib < 0 || (chunk_left >> (ChunkW - 4)) != 0) begin
                body_done = 1'b1;
                r.err = ERR_BAD_SIZE;
              end else begin
                chunk_left = {chunk_left[ChunkW-5:0], nib[3:0]};
                digit_seen = 1'b1;
              end
            end
          end
          PH_CR: begin
            if (b != ChLf) begin
              body_done = 1'b1;
              r.err = ERR_BAD_SIZE;
            end else if (!digit_seen) begin
              body_done = 1'b1;
              r.err = ERR_EMPTY_SIZE;
            end else begin
              digit_seen = 1'b0;
              last_chunk = (chunk_left == '0);
              if (last_chunk) begin
                chk_phase = PH_SKIP;
                skip_left = 2'd2;
              end else begin
                chk_phase = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            bump_count();
            if (chunk_left != '0) chunk_left--;
            if (chunk_left == '0) begin
              chk_phase = PH_SKIP;
              skip_left = 2'd2;
            end
            r.pay_valid = 1'b1;
            r.pay_byte  = b;
          end
          default: begin
            if (skip_left != '0) skip_left--;
            if (skip_left == '0) begin
              chk_phase  = PH_SIZE;
              chunk_left = '0;
              if (last_chunk) begin
                body_done  = 1'b1;
                r.body_end = 1'b1;
              end
            end
          end
        endcase
      end
      MODE_LENGTH: begin
        if (byte_cnt >= len_q) begin
          body_done = 1'b1;
          r.err = ERR_AFTER_END;
        end else begin
          bump_count();
          r.pay_valid = 1'b1;
          r.pay_byte  = b;
          if (byte_cnt >= len_q) begin
            body_done  = 1'b1;
            r.body_end = 1'b1;
          end
        end
      end
      default: begin
        bump_count();
        r.pay_valid = 1'b1;
        r.pay_byte  = b;
      end
    endcase
    return r;
  endfunction

  task automatic push_req(kind_e k, logic [7:0] b);
    body_req_t t;
    t.kind = k;
    t.data = b;
    pending_q.push_back(t);
  endtask

  task automatic push_data(int unsigned n);
    repeat (n) push_req(KIND_BYTE, 8'($urandom_range(0, 255)));
  endtask

  // Size line with optional leading zeros and mixed-case digits.
  task automatic push_size_line(int unsigned size, int unsigned pad);
    int nd;
    nd = 1;
    while (nd < 8 && (size >> (4 * nd)) != 0) nd++;
    repeat (pad) push_req(KIND_BYTE, "0");
    for (int i = nd - 1; i >= 0; i--) begin
      push_req(KIND_BYTE, hex_char(4'(size >> (4 * i)), 1'($urandom_range(0, 1))));
    end
    push_req(KIND_BYTE, ChCr);
    push_req(KIND_BYTE, ChLf);
  endtask

  // Trailer bytes are not checked by the block, so they are mostly CR LF.
  task automatic push_trailer();
    if ($urandom_range(0, 3) != 0) begin
      push_req(KIND_BYTE, ChCr);
      push_req(KIND_BYTE, ChLf);
    end else begin
      push_data(2);
    end
  endtask

  task automatic push_chunk();
    int unsigned sz;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80)      sz = $urandom_range(1, 16);
    else if (pick < 96) sz = $urandom_range(17, 80);
    else                sz = $urandom_range(256, 300);
    push_size_line(sz, $urandom_range(0, 2));
    push_data(sz);
    push_trailer();
  endtask

  // Waits until every queued request has been answered.
  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_BODY_MODE) mode_q = mode_e'(val[1:0]);
    else                      len_q  = val[LenW-1:0];
  endtask

  // Request driver: predicts each accepted request and offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i     <= KIND_BYTE;
      in_byte_i  <= '0;
      send_gap   = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expect_q.push_back(predict_body(kind_e'(kind_i), in_byte_i));
        accepted_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          drv_req = pending_q.pop_front();
          in_valid_i <= 1'b1;
          kind_i     <= drv_req.kind;
          in_byte_i  <= drv_req.data;
          if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 8);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with one long hold-off to fill the block.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (hold_cycles != 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (!long_hold_done && accepted_cnt >= 300) begin
        long_hold_done = 1'b1;
        hold_cycles = 60;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold_cycles = $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result monitor: each result must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expect_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        fail_cnt++;
      end else begin
        mon_want = expect_q.pop_front();
        if (payload_valid_o !== mon_want.pay_valid) begin
          $error("payload_valid: expected %0d, got %0d", mon_want.pay_valid, payload_valid_o);
          fail_cnt++;
        end
        if (payload_byte_o !== mon_want.pay_byte) begin
          $error("payload_byte: expected %0h, got %0h", mon_want.pay_byte, payload_byte_o);
          fail_cnt++;
        end
        if (body_end_o !== mon_want.body_end) begin
          $error("body_end: expected %0d, got %0d", mon_want.body_end, body_end_o);
          fail_cnt++;
        end
        if (error_code_o !== mon_want.err) begin
          $error("error_code: expected %0d, got %0d", mon_want.err, error_code_o);
          fail_cnt++;
        end
      end
    end
  end

  // Stimulus sequence and final verdict.
  initial begin
    int unsigned rest_len;
    int unsigned split_len;
    int unsigned k;
    logic [7:0]  odd_ch;
    finale_e     finale;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening in chunked mode: smallest chunk, byte extremes,
    // a padded size line and unchecked trailer bytes.
    write_reg(REG_CONTENT_LENGTH, '0);
    push_size_line(1, 0);
    push_req(KIND_BYTE, 8'h00);
    push_req(KIND_BYTE, ChCr);
    push_req(KIND_BYTE, ChLf);
    push_size_line(2, 7);
    push_req(KIND_BYTE, 8'hFF);
    push_req(KIND_BYTE, 8'h80);
    push_data(2);

    // Well-formed chunks with random sizes and content.
    while (pending_q.size() < 470) push_chunk();

    // Leave a chunk half read so that the other modes run mid-chunk.
    split_len = $urandom_range(20, 40);
    k = $urandom_range(1, split_len - 1);
    push_size_line(split_len, 0);
    push_data(k);
    rest_len = split_len - k;
    drain();

    // Until-close mode, in both of its codes.
    write_reg(REG_BODY_MODE, CfgDataW'(MODE_CLOSE));
    push_data(150);
    drain();
    write_reg(REG_BODY_MODE, CfgDataW'(MODE_CLOSE_ALT));
    push_data(100);
    drain();

    // Length mode with the largest length, which is never reached.
    write_reg(REG_CONTENT_LENGTH, '1);
    write_reg(REG_BODY_MODE, CfgDataW'(MODE_LENGTH));
    push_data(120);
    drain();

    // Back to chunked mode: finish the open chunk, then more chunks.
    calm = 1'b1;
    write_reg(REG_BODY_MODE, CfgDataW'(MODE_CHUNKED));
    push_data(rest_len);
    push_trailer();
    while (pending_q.size() < 150) push_chunk();
    drain();

    // One way of ending the body, chosen at random.
    finale = finale_e'($urandom_range(FIN_LAST_CHUNK, FIN_OPEN_CLOSE));
    case (finale)
      FIN_LAST_CHUNK: begin
        push_size_line(0, $urandom_range(0, 3));
        push_trailer();
      end
      FIN_EMPTY_LINE: begin
        push_req(KIND_BYTE, ChCr);
        push_req(KIND_BYTE, ChLf);
      end
      FIN_BAD_DIGIT: begin
        repeat ($urandom_range(0, 3)) push_req(KIND_BYTE, hex_char(4'($urandom_range(0, 15)), 1'b1));
        do odd_ch = 8'($urandom_range(0, 255)); while (hex_nibble(odd_ch) >= 0 || odd_ch == ChCr);
        push_req(KIND_BYTE, odd_ch);
      end
      FIN_BAD_LF: begin
        push_req(KIND_BYTE, hex_char(4'($urandom_range(0, 15)), 1'b0));
        push_req(KIND_BYTE, ChCr);
        do odd_ch = 8'($urandom_range(0, 255)); while (odd_ch == ChLf);
        push_req(KIND_BYTE, odd_ch);
      end
      FIN_OVERSIZE: begin
        // Nine digits with a non-zero lead cannot fit the chunk size.
        push_req(KIND_BYTE, hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
        repeat (8) push_req(KIND_BYTE, hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        push_req(KIND_BYTE, ChCr);
        push_req(KIND_BYTE, ChLf);
      end
      FIN_CHUNK_CLOSE: begin
        push_size_line($urandom_range(4, 20), 0);
        push_data($urandom_range(1, 3));
        push_req(KIND_CLOSE, 8'($urandom_range(0, 255)));
      end
      FIN_LEN_DONE: begin
        k = $urandom_range(1, 5);
        write_reg(REG_CONTENT_LENGTH, byte_cnt + k);
        write_reg(REG_BODY_MODE, CfgDataW'(MODE_LENGTH));
        push_data(k);
      end
      FIN_LEN_ZERO: begin
        write_reg(REG_CONTENT_LENGTH, '0);
        write_reg(REG_BODY_MODE, CfgDataW'(MODE_LENGTH));
        push_data(1);
      end
      FIN_LEN_SHORT: begin
        write_reg(REG_CONTENT_LENGTH, byte_cnt + $urandom_range(1, 9));
        write_reg(REG_BODY_MODE, CfgDataW'(MODE_LENGTH));
        push_req(KIND_CLOSE, 8'($urandom_range(0, 255)));
      end
      FIN_LEN_CLOSE: begin
        write_reg(REG_CONTENT_LENGTH, byte_cnt);
        write_reg(REG_BODY_MODE, CfgDataW'(MODE_LENGTH));
        push_req(KIND_CLOSE, 8'($urandom_range(0, 255)));
      end
      default: begin
        write_reg(REG_BODY_MODE, CfgDataW'(MODE_CLOSE));
        push_data($urandom_range(0, 4));
        push_req(KIND_CLOSE, 8'($urandom_range(0, 255)));
      end
    endcase

    // Traffic after the body has ended: bytes and closes mixed.
    repeat (40) push_req(kind_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

    k = 0;
    while (k < 5000 && (pending_q.size() != 0 || in_valid_i || expect_q.size() != 0)) begin
      @(posedge clk_i);
      k++;
    end
    repeat (8) @(posedge clk_i);
    if (expect_q.size() != 0) begin
      $error("%0d predicted results never arrived", expect_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog in case the block stops answering.
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
